[rtl/itaf_pkg.sv]
// Shared constants and types of the integer to ASCII formatter.
package itaf_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned HalfWidth  = 16;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned NumDigits  = 10;
  localparam int unsigned DigitWidth = 4;
  localparam int unsigned BcdWidth   = NumDigits * DigitWidth;
  localparam int unsigned CountWidth = $clog2(NumDigits + 1);
  localparam int unsigned ShiftCntW  = $clog2(ValueWidth + 1);

  // Format kinds
  localparam logic [1:0] KindDec  = 2'd0;
  localparam logic [1:0] KindHex  = 2'd1;
  localparam logic [1:0] KindBin  = 2'd2;
  localparam logic [1:0] KindFour = 2'd3;

  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharLetter = 8'h41;
  localparam logic [7:0] CharMinus  = 8'h2D;

  // Digit string handed to the emitter, most significant digit in the top nibble.
  typedef struct packed {
    logic [BcdWidth-1:0]   digits;
    logic [CountWidth-1:0] count;
    logic                  neg;
    logic                  suppress;
  } emit_load_t;

endpackage

[rtl/itaf_dabble.sv]
// Bit-serial binary to BCD converter (shift and add three).
module itaf_dabble (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic [itaf_pkg::ValueWidth-1:0] bin_i,
  input  logic [itaf_pkg::ShiftCntW-1:0]  shifts_i,
  output logic                          done_o,
  output logic [itaf_pkg::BcdWidth-1:0]   bcd_o
);
  import itaf_pkg::*;

  logic [ValueWidth-1:0] bin_q, bin_d;
  logic [BcdWidth-1:0]   bcd_q, bcd_d, adj;
  logic [ShiftCntW-1:0]  cnt_q, cnt_d;
  logic                  run_q, run_d;
  logic                  done_q, done_d;

  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      adj[i*DigitWidth +: DigitWidth] =
        (bcd_q[i*DigitWidth +: DigitWidth] >= 4'd5) ?
        bcd_q[i*DigitWidth +: DigitWidth] + 4'd3 : bcd_q[i*DigitWidth +: DigitWidth];
    end
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (load_i) begin
      bin_d = bin_i;
      bcd_d = '0;
      cnt_d = shifts_i;
      run_d = 1'b1;
    end else if (run_q) begin
      bcd_d = {adj[BcdWidth-2:0], bin_q[ValueWidth-1]};
      bin_d = {bin_q[ValueWidth-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == ShiftCntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

[rtl/itaf_emit.sv]
// Character emitter: shifts digits out one per cycle as ASCII.
module itaf_emit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  itaf_pkg::emit_load_t load_data_i,
  output logic                 active_o,
  output logic                 char_valid_o,
  output logic [7:0]           character_o,
  output logic                 last_o
);
  import itaf_pkg::*;

  logic [BcdWidth-1:0]   digits_q, digits_d;
  logic [CountWidth-1:0] left_q, left_d;
  logic                  sign_q, sign_d;
  logic                  supp_q, supp_d;
  logic                  active_q, active_d;
  logic                  valid_q, valid_d;
  logic [7:0]            char_q, char_d;
  logic                  last_q, last_d;
  logic [DigitWidth-1:0] top;

  assign top = digits_q[BcdWidth-1 -: DigitWidth];

  always_comb begin
    digits_d = digits_q;
    left_d   = left_q;
    sign_d   = sign_q;
    supp_d   = supp_q;
    active_d = active_q;
    valid_d  = 1'b0;
    char_d   = char_q;
    last_d   = last_q;
    if (load_i) begin
      digits_d = load_data_i.digits;
      left_d   = load_data_i.count;
      sign_d   = load_data_i.neg;
      supp_d   = load_data_i.suppress;
      active_d = 1'b1;
    end else if (active_q) begin
      priority if (sign_q) begin
        sign_d  = 1'b0;
        valid_d = 1'b1;
        char_d  = CharMinus;
        last_d  = 1'b0;
      end else if (supp_q && top == '0 && left_q > CountWidth'(1)) begin
        digits_d = {digits_q[BcdWidth-DigitWidth-1:0], {DigitWidth{1'b0}}};
        left_d   = left_q - 1'b1;
      end else begin
        supp_d   = 1'b0;
        valid_d  = 1'b1;
        char_d   = (top < 4'd10) ? CharZero + {4'd0, top}
                                 : CharLetter + {4'd0, top} - 8'd10;
        last_d   = (left_q == CountWidth'(1));
        digits_d = {digits_q[BcdWidth-DigitWidth-1:0], {DigitWidth{1'b0}}};
        left_d   = left_q - 1'b1;
        if (left_q == CountWidth'(1)) active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      valid_q  <= 1'b0;
      sign_q   <= 1'b0;
      supp_q   <= 1'b0;
      left_q   <= '0;
    end else begin
      active_q <= active_d;
      valid_q  <= valid_d;
      sign_q   <= sign_d;
      supp_q   <= supp_d;
      left_q   <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digits_q <= digits_d;
    char_q   <= char_d;
    last_q   <= last_d;
  end

  assign active_o     = active_q;
  assign char_valid_o = valid_q;
  assign character_o  = char_q;
  assign last_o       = last_q;

endmodule

[rtl/integer_to_ascii_formatter.sv]
// Signed decimal and four-digit values pass through the shift-and-add-three converter
// first; hex and binary values load the emitter straight away. The emitter registers
// its load, then puts out one character per cycle through its output register, except
// on cycles where it skips a leading zero.
// Throughput: one value at a time; start is taken only while busy_o is low.
// The receiver cannot stall: each character strobes char_valid_o for one cycle.
// Reset (rst_ni low, asynchronous) returns the block to idle with no output pending.
module integer_to_ascii_formatter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [1:0]  kind_i,
  input  logic signed [31:0] value_i,
  output logic        busy_o,
  output logic        char_valid_o,
  output logic [7:0]  character_o,
  output logic        last_o
);
  import itaf_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StEmit
  } state_e;

  state_e state_q;
  logic   four_q;   // conversion result is the four-digit kind
  logic   neg_q;    // signed decimal value was negative

  logic                  accept;
  logic                  dab_load;
  logic [ValueWidth-1:0] dab_bin;
  logic [ShiftCntW-1:0]  dab_shifts;
  logic                  dab_done;
  logic [BcdWidth-1:0]   dab_bcd;
  logic                  emit_load;
  emit_load_t            emit_data;
  logic                  emit_active;
  logic [ValueWidth-1:0] raw;

  assign raw    = value_i;
  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != StIdle);

  // Conversion goes through the shift-and-add-three unit only for decimal kinds.
  assign dab_load = accept && (kind_i == KindDec || kind_i == KindFour);

  always_comb begin
    if (kind_i == KindDec) begin
      dab_bin    = raw[ValueWidth-1] ? (~raw + 1'b1) : raw;
      dab_shifts = ShiftCntW'(ValueWidth);
    end else begin
      dab_bin    = {raw[HalfWidth-1:0], {(ValueWidth-HalfWidth){1'b0}}};
      dab_shifts = ShiftCntW'(HalfWidth);
    end
  end

  // Emitter loads straight from the input for hex and binary, and from the
  // BCD register when a conversion finishes.
  always_comb begin
    emit_load = 1'b0;
    emit_data = '0;
    if (state_q == StConv && dab_done) begin
      emit_load = 1'b1;
      if (four_q) begin
        // Low four BCD digits of the 16-bit value are the value modulo 10000.
        emit_data.digits   = {dab_bcd[4*DigitWidth-1:0],
                              {(BcdWidth-4*DigitWidth){1'b0}}};
        emit_data.count    = CountWidth'(4);
        emit_data.suppress = 1'b0;
        emit_data.neg      = 1'b0;
      end else begin
        emit_data.digits   = dab_bcd;
        emit_data.count    = CountWidth'(NumDigits);
        emit_data.suppress = 1'b1;
        emit_data.neg      = neg_q;
      end
    end else if (accept && kind_i == KindHex) begin
      emit_load          = 1'b1;
      emit_data.digits   = {raw[HalfWidth-1:0], {(BcdWidth-HalfWidth){1'b0}}};
      emit_data.count    = CountWidth'(4);
      emit_data.suppress = 1'b1;
    end else if (accept && kind_i == KindBin) begin
      emit_load = 1'b1;
      for (int b = 0; b < ByteWidth; b++) begin
        emit_data.digits[BcdWidth-1-b*DigitWidth -: DigitWidth] =
          {3'b000, raw[ByteWidth-1-b]};
      end
      emit_data.count = CountWidth'(ByteWidth);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      four_q  <= 1'b0;
      neg_q   <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            four_q  <= (kind_i == KindFour);
            neg_q   <= (kind_i == KindDec) && raw[ValueWidth-1];
            state_q <= dab_load ? StConv : StEmit;
          end
        end
        StConv: begin
          if (dab_done) state_q <= StEmit;
        end
        StEmit: begin
          if (!emit_active) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  itaf_dabble u_dabble (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (dab_load),
    .bin_i    (dab_bin),
    .shifts_i (dab_shifts),
    .done_o   (dab_done),
    .bcd_o    (dab_bcd)
  );

  itaf_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (emit_load),
    .load_data_i  (emit_data),
    .active_o     (emit_active),
    .char_valid_o (char_valid_o),
    .character_o  (character_o),
    .last_o       (last_o)
  );

endmodule

[tb/integer_to_ascii_formatter_tb.sv]
// Self-checking testbench of the integer to ASCII formatter: directed table, then random values.
module integer_to_ascii_formatter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import itaf_pkg::*;

  // One stimulus row. An empty text means the predictor supplies the characters.
  typedef struct {
    logic [1:0]  kind;
    logic [31:0] value;
    string       text;
  } fmt_row_t;

  // One expected character. item tags the value it belongs to, for reports.
  typedef struct {
    logic [7:0] code;
    logic       last;
    int         item;
  } char_exp_t;

  localparam int RandomValues  = 400;
  localparam int CalmTail      = 60;   // last random values go without idle bursts
  localparam int DrainCycles   = 80;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  logic [1:0]  kind_i;
  logic signed [31:0] value_i;
  logic        busy_o;
  logic        char_valid_o;
  logic [7:0]  character_o;
  logic        last_o;

  // Characters still owed by the block, oldest first.
  char_exp_t   pending_chars[$];
  fmt_row_t    directed_rows[$];

  // Scratch text built for one accepted value.
  logic [7:0]  fmt_buf [11];
  int          fmt_len;

  // Text typed in by the driver for the value it is offering, else empty.
  string       typed_text;

  int          values_taken;
  int          chars_seen;
  int          errors;
  int          kind_seen [4];

  integer_to_ascii_formatter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .kind_i      (kind_i),
    .value_i     (value_i),
    .busy_o      (busy_o),
    .char_valid_o(char_valid_o),
    .character_o (character_o),
    .last_o      (last_o)
  );

  always #1 clk_i = ~clk_i;

  // Run limit: far beyond the slowest legal run.
  initial begin
    #1ms;
    $display("integer_to_ascii_formatter verification failed");
    $finish;
  end

  function automatic void mismatch(input string msg);
    errors++;
    $display("%0t: %s", $time, msg);
  endfunction

  function automatic void put_char(input logic [7:0] c);
    fmt_buf[fmt_len] = c;
    fmt_len++;
  endfunction

  // Predictor: fills fmt_buf/fmt_len with the characters one value should produce.
  function automatic void format_value(input logic [1:0] kind, input logic [31:0] value);
    logic [7:0]  rev [10];
    logic [31:0] mag;
    logic [31:0] nib;
    int          nd;
    int          b;
    fmt_len = 0;
    nd      = 0;
    case (kind)
      KindDec: begin
        // Magnitude in 32-bit unsigned arithmetic, so the most negative value
        // comes out as 2147483648 rather than overflowing.
        mag = value;
        if (value[31]) begin
          put_char(CharMinus);
          mag = -value;
        end
        do begin
          rev[nd] = CharZero + 8'(mag % 10);
          nd++;
          mag = mag / 10;
        end while (mag != 0);
        while (nd > 0) begin
          nd--;
          put_char(rev[nd]);
        end
      end
      KindHex: begin
        // Only the low half counts; zero still yields a single '0'.
        mag = {16'h0, value[15:0]};
        do begin
          nib     = mag % 16;
          rev[nd] = (nib <= 9) ? CharZero + 8'(nib) : CharLetter + 8'(nib - 10);
          nd++;
          mag = mag / 16;
        end while (mag != 0);
        while (nd > 0) begin
          nd--;
          put_char(rev[nd]);
        end
      end
      KindBin: begin
        for (b = 7; b >= 0; b--) begin
          put_char(value[b] ? CharZero + 8'd1 : CharZero);
        end
      end
      default: begin
        // Four-digit: low half modulo 10000, leading zeros kept.
        mag = {16'h0, value[15:0]} % 10000;
        put_char(CharZero + 8'(mag / 1000));
        put_char(CharZero + 8'((mag / 100) % 10));
        put_char(CharZero + 8'((mag / 10) % 10));
        put_char(CharZero + 8'(mag % 10));
      end
    endcase
  endfunction

  // Monitor and scoreboard. Characters are checked before a new transfer is
  // queued, so a character landing on the same edge belongs to the older value.
  always @(posedge clk_i) begin : char_check
    char_exp_t want;
    int        k;
    if (rst_ni) begin
      if (char_valid_o) begin
        chars_seen++;
        if (pending_chars.size() == 0) begin
          mismatch($sformatf("unexpected character 0x%02h last %b, nothing pending",
                             character_o, last_o));
        end else begin
          want = pending_chars.pop_front();
          if (character_o !== want.code) begin
            mismatch($sformatf("value #%0d character: expected 0x%02h actual 0x%02h",
                               want.item, want.code, character_o));
          end
          if (last_o !== want.last) begin
            mismatch($sformatf("value #%0d last: expected %b actual %b",
                               want.item, want.last, last_o));
          end
        end
      end
      if (start_i && !busy_o) begin
        if (typed_text.len() != 0) begin
          fmt_len = typed_text.len();
          for (k = 0; k < fmt_len; k++) begin
            fmt_buf[k] = typed_text[k];
          end
        end else begin
          format_value(kind_i, value_i);
        end
        for (k = 0; k < fmt_len; k++) begin
          want.code = fmt_buf[k];
          want.last = (k == fmt_len - 1);
          want.item = values_taken;
          pending_chars.push_back(want);
        end
        kind_seen[kind_i]++;
        values_taken++;
      end
    end
  end

  function automatic void add_row(input logic [1:0] kind, input logic [31:0] value,
                                  input string text);
    fmt_row_t row;
    row.kind  = kind;
    row.value = value;
    row.text  = text;
    directed_rows.push_back(row);
  endfunction

  // Offer one value at a falling edge and hold it until the block takes it.
  task automatic send_value(input logic [1:0] kind, input logic [31:0] value,
                            input string text);
    int taken;
    taken      = values_taken;
    start_i    = 1'b1;
    kind_i     = kind;
    value_i    = value;
    typed_text = text;
    do @(negedge clk_i); while (values_taken == taken);
  endtask

  // Sender idle burst; the bus carries junk while start is low.
  task automatic idle_burst(input int cycles);
    start_i    = 1'b0;
    typed_text = "";
    repeat (cycles) begin
      kind_i  = 2'($urandom_range(0, 3));
      value_i = $urandom;
      @(negedge clk_i);
    end
  endtask

  // Random value with weight on digit-count boundaries and the low-half wraps.
  function automatic logic [31:0] pick_value();
    logic [31:0] r;
    logic [31:0] p;
    int          k;
    r = $urandom;
    case ($urandom_range(0, 5))
      0, 1: ;
      2: r = $urandom_range(0, 20);
      3: r = -$urandom_range(1, 20);
      4: begin
        p = 1;
        k = $urandom_range(0, 9);
        repeat (k) p = p * 10;
        r = p - 1 + $urandom_range(0, 2);
        if ($urandom_range(0, 1) == 1) r = -r;
      end
      default: r[15:0] = 16'(10000 * $urandom_range(0, 6) + $urandom_range(0, 2));
    endcase
    return r;
  endfunction

  initial begin : stimulus
    int i;
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    kind_i     = KindDec;
    value_i    = '0;
    typed_text = "";

    // Directed table: extremes, every kind, and the special cases.
    add_row(KindDec,  32'd0,          "0");
    add_row(KindDec,  32'd9,          "9");
    add_row(KindDec,  32'd10,         "10");
    add_row(KindDec,  32'hFFFF_FFFF,  "-1");
    add_row(KindDec,  32'h7FFF_FFFF,  "2147483647");
    add_row(KindDec,  32'h8000_0000,  "-2147483648");
    add_row(KindDec,  32'd1000000000, "1000000000");
    add_row(KindDec,  -32'sd123456789, "");
    add_row(KindDec,  32'd90210,      "");
    add_row(KindHex,  32'd0,          "0");
    add_row(KindHex,  32'h0001_0000,  "0");
    add_row(KindHex,  32'h0000_FFFF,  "FFFF");
    add_row(KindHex,  32'hFFFF_000A,  "A");
    add_row(KindHex,  32'h1234_ABCD,  "ABCD");
    add_row(KindHex,  32'h0000_0F09,  "");
    add_row(KindBin,  32'd0,          "00000000");
    add_row(KindBin,  32'h0000_00FF,  "11111111");
    add_row(KindBin,  32'hFFFF_FF5A,  "");
    add_row(KindFour, 32'd0,          "0000");
    add_row(KindFour, 32'd9999,       "9999");
    add_row(KindFour, 32'd10000,      "0000");
    add_row(KindFour, 32'h0000_FFFF,  "5535");
    add_row(KindFour, 32'h8000_002A,  "");

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      if ($urandom_range(0, 2) == 0) idle_burst($urandom_range(1, 19));
      send_value(directed_rows[i].kind, directed_rows[i].value, directed_rows[i].text);
    end

    // Random part; bursts of idle time except in the calm tail.
    for (i = 0; i < RandomValues; i++) begin
      if (i < RandomValues - CalmTail && $urandom_range(0, 2) == 0) begin
        idle_burst($urandom_range(1, 19));
      end
      send_value(2'($urandom_range(0, 3)), pick_value(), "");
    end
    start_i    = 1'b0;
    typed_text = "";

    // Drain, then watch for stray characters.
    while (pending_chars.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Ran %0d values: %0d signed decimal, %0d hex, %0d binary, %0d four-digit.",
             values_taken, kind_seen[KindDec], kind_seen[KindHex], kind_seen[KindBin],
             kind_seen[KindFour]);
    $display("Checked %0d characters; %0d mismatches.", chars_seen, errors);
    if (errors == 0) begin
      $display("integer_to_ascii_formatter verification clean");
    end else begin
      $display("integer_to_ascii_formatter verification failed");
    end
    $finish;
  end

endmodule
